// ----- rtl/core/ipd_pkg.sv -----
// instruction predecoder package: opcode table, operand classes and match result type
package ipd_pkg;

    localparam int ENTRY_COUNT = 84;
    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    localparam int WORD_W      = 16;

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_TWO_OP  = 3'd1,
        CLS_REG_DST = 3'd2,
        CLS_SINGLE  = 3'd3,
        CLS_BRANCH  = 3'd4,
        CLS_SOB     = 3'd5,
        CLS_TRAP    = 3'd6,
        CLS_RTS     = 3'd7
    } cls_t;

    typedef struct packed {
        logic             matched;
        logic [IDX_W-1:0] index;
        cls_t             cls;
    } match_t;

    localparam logic [WORD_W-1:0] ENTRY_MATCH [ENTRY_COUNT] = '{
        16'o000241, 16'o000242, 16'o000244, 16'o000250,
        16'o000257, 16'o000261, 16'o000262, 16'o000264,
        16'o000270, 16'o000277, 16'o000240, 16'o000000,
        16'o000001, 16'o000002, 16'o000003, 16'o000004,
        16'o000005, 16'o000006, 16'o000007, 16'o000200,
        16'o000210, 16'o000220,
        16'o005000, 16'o105000, 16'o005100, 16'o105100,
        16'o005200, 16'o105200, 16'o005300, 16'o105300,
        16'o005400, 16'o105400, 16'o005500, 16'o105500,
        16'o005600, 16'o105600, 16'o005700, 16'o105700,
        16'o006000, 16'o106000, 16'o006100, 16'o106100,
        16'o006200, 16'o106200, 16'o006300, 16'o106300,
        16'o106400, 16'o106700, 16'o000300, 16'o000100,
        16'o000400, 16'o001000, 16'o001400, 16'o002000,
        16'o002400, 16'o003000, 16'o003400, 16'o100000,
        16'o100400, 16'o101000, 16'o101400, 16'o102000,
        16'o102400, 16'o103000, 16'o103000, 16'o103400,
        16'o103400, 16'o104000, 16'o104400,
        16'o077000, 16'o074000, 16'o004000,
        16'o010000, 16'o110000, 16'o020000, 16'o120000,
        16'o030000, 16'o130000, 16'o040000, 16'o140000,
        16'o050000, 16'o150000, 16'o060000, 16'o160000
    };

    localparam logic [WORD_W-1:0] ENTRY_MASK [ENTRY_COUNT] = '{
        16'o177777, 16'o177777, 16'o177777, 16'o177777,
        16'o177777, 16'o177777, 16'o177777, 16'o177777,
        16'o177777, 16'o177777, 16'o177777, 16'o177777,
        16'o177777, 16'o177777, 16'o177777, 16'o177777,
        16'o177777, 16'o177777, 16'o177777, 16'o177770,
        16'o177770, 16'o177770,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177700, 16'o177700, 16'o177700, 16'o177700,
        16'o177400, 16'o177400, 16'o177400, 16'o177400,
        16'o177400, 16'o177400, 16'o177400, 16'o177400,
        16'o177400, 16'o177400, 16'o177400, 16'o177400,
        16'o177400, 16'o177400, 16'o177400, 16'o177400,
        16'o177400, 16'o177400, 16'o177400,
        16'o177000, 16'o177000, 16'o177000,
        16'o170000, 16'o170000, 16'o170000, 16'o170000,
        16'o170000, 16'o170000, 16'o170000, 16'o170000,
        16'o170000, 16'o170000, 16'o170000, 16'o170000
    };

    function automatic cls_t class_of(input logic [IDX_W-1:0] idx);
        cls_t c;
        case (idx) inside
            [7'd0:7'd18]:  c = CLS_NONE;
            [7'd19:7'd21]: c = CLS_RTS;
            [7'd22:7'd49]: c = CLS_SINGLE;
            [7'd50:7'd66]: c = CLS_BRANCH;
            [7'd67:7'd68]: c = CLS_TRAP;
            7'd69:         c = CLS_SOB;
            [7'd70:7'd71]: c = CLS_REG_DST;
            [7'd72:7'd83]: c = CLS_TWO_OP;
            default:       c = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/ipd_match.sv -----
// opcode table match: first matching entry, its index and operand class
module ipd_match
    import ipd_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output match_t            result
);

    logic             hit;
    logic [IDX_W-1:0] idx;

    // scan from the top so the lowest matching index wins
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--)
        begin
            if ((word & ENTRY_MASK[i]) == ENTRY_MATCH[i])
            begin
                hit = 1'b1;
                idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        result.matched = hit;
        result.index   = idx;
        result.cls     = hit ? class_of(idx) : CLS_NONE;
    end

endmodule

// ----- rtl/core/instruction_predecoder.sv -----
// instruction predecoder top level: input register, decode, result register
//
//  channel   handshake          fields
//  --------  -----------------  --------------------------------------------------
//  input     start / busy       instr_address, instr_word, ext_word_1, ext_word_2
//  result    done (strobe)      matched, table_index, operand_class, length_bytes,
//                               src/dst mode and reg, src_value, dst_value,
//                               branch_target
//
//  one beat per cycle in, one per cycle out; each start passes through the input
//  register, the decode and the result register before its result appears.
//  busy stays low: the receiver cannot stall, so nothing ever holds the input off.
//  reset clears the valid bits only; no result strobes until a start is taken.
module instruction_predecoder
    import ipd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] instr_address,
    input  logic [WORD_W-1:0] instr_word,
    input  logic [WORD_W-1:0] ext_word_1,
    input  logic [WORD_W-1:0] ext_word_2,
    output logic              done,
    output logic              matched,
    output logic [IDX_W-1:0]  table_index,
    output logic [2:0]        operand_class,
    output logic [2:0]        length_bytes,
    output logic [2:0]        src_mode,
    output logic [2:0]        src_reg,
    output logic [2:0]        dst_mode,
    output logic [2:0]        dst_reg,
    output logic [WORD_W-1:0] src_value,
    output logic [WORD_W-1:0] dst_value,
    output logic [WORD_W-1:0] branch_target
);

    function automatic logic uses_ext(input logic [2:0] mode, input logic [2:0] rn);
        return (mode >= 3'd6) || (((mode == 3'd2) || (mode == 3'd3)) && (rn == 3'd7));
    endfunction

    function automatic logic pc_rel(input logic [2:0] mode, input logic [2:0] rn);
        return (mode >= 3'd6) && (rn == 3'd7);
    endfunction

    logic              in_valid_reg;
    logic [WORD_W-1:0] addr_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] ext1_reg;
    logic [WORD_W-1:0] ext2_reg;

    match_t            mres;
    logic              src_ext;
    logic              dst_ext;
    logic [WORD_W-1:0] loc1;
    logic [WORD_W-1:0] loc2;
    logic [WORD_W-1:0] loc3;
    logic [WORD_W-1:0] dst_word;
    logic [WORD_W-1:0] dst_loc;
    logic [WORD_W-1:0] br_off;
    logic [WORD_W-1:0] sob_off;

    logic              done_reg;
    logic              matched_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [2:0]        class_reg;
    logic [2:0]        length_reg;
    logic [2:0]        src_mode_reg;
    logic [2:0]        src_reg_reg;
    logic [2:0]        dst_mode_reg;
    logic [2:0]        dst_reg_reg;
    logic [WORD_W-1:0] src_value_reg;
    logic [WORD_W-1:0] dst_value_reg;
    logic [WORD_W-1:0] target_reg;

    logic [2:0]        length_next;
    logic [WORD_W-1:0] src_value_next;
    logic [WORD_W-1:0] dst_value_next;
    logic [WORD_W-1:0] target_next;

    assign busy = 1'b0;

    // input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg <= instr_address;
            word_reg <= instr_word;
            ext1_reg <= ext_word_1;
            ext2_reg <= ext_word_2;
        end
    end

    ipd_match u_match
    (
        .word   (word_reg),
        .result (mres)
    );

    always_comb
    begin
        src_ext  = (mres.cls == CLS_TWO_OP) && uses_ext(word_reg[11:9], word_reg[8:6]);
        dst_ext  = ((mres.cls == CLS_TWO_OP) || (mres.cls == CLS_REG_DST)
                    || (mres.cls == CLS_SINGLE)) && uses_ext(word_reg[5:3], word_reg[2:0]);
        loc1     = addr_reg + 16'd2;
        loc2     = addr_reg + 16'd4;
        loc3     = addr_reg + 16'd6;
        dst_word = src_ext ? ext2_reg : ext1_reg;
        dst_loc  = src_ext ? loc3 : loc2;
        br_off   = {{7{word_reg[7]}}, word_reg[7:0], 1'b0};
        sob_off  = {9'd0, word_reg[5:0], 1'b0};

        length_next = 3'd2 + (src_ext ? 3'd2 : 3'd0) + (dst_ext ? 3'd2 : 3'd0);

        src_value_next = '0;
        if (src_ext)
        begin
            src_value_next = pc_rel(word_reg[11:9], word_reg[8:6]) ? ext1_reg + loc2
                                                                   : ext1_reg;
        end

        dst_value_next = '0;
        if (dst_ext)
        begin
            dst_value_next = pc_rel(word_reg[5:3], word_reg[2:0]) ? dst_word + dst_loc
                                                                  : dst_word;
        end

        case (mres.cls)
            CLS_BRANCH: target_next = loc1 + br_off;
            CLS_SOB:    target_next = loc1 - sob_off;
            default:    target_next = '0;
        endcase
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            matched_reg   <= mres.matched;
            index_reg     <= mres.index;
            class_reg     <= mres.cls;
            length_reg    <= length_next;
            src_mode_reg  <= word_reg[11:9];
            src_reg_reg   <= word_reg[8:6];
            dst_mode_reg  <= word_reg[5:3];
            dst_reg_reg   <= word_reg[2:0];
            src_value_reg <= src_value_next;
            dst_value_reg <= dst_value_next;
            target_reg    <= target_next;
        end
    end

    assign done          = done_reg;
    assign matched       = matched_reg;
    assign table_index   = index_reg;
    assign operand_class = class_reg;
    assign length_bytes  = length_reg;
    assign src_mode      = src_mode_reg;
    assign src_reg       = src_reg_reg;
    assign dst_mode      = dst_mode_reg;
    assign dst_reg       = dst_reg_reg;
    assign src_value     = src_value_reg;
    assign dst_value     = dst_value_reg;
    assign branch_target = target_reg;

endmodule
